>>> rtl/core/clci_pkg.sv
package clci_pkg;

   // Reset values of the configuration registers
   localparam int ROWS_RESET = 4;
   localparam int COLS_RESET = 20;

   // Default geometry limits
   localparam int MAX_ROWS_DEF = 4;
   localparam int MAX_COLS_DEF = 20;

   // Configuration register indexes
   localparam logic [1:0] CSR_ROWS = 2'd0;
   localparam logic [1:0] CSR_COLS = 2'd1;

   // Command bytes
   localparam logic [7:0] CMD_HOME        = 8'd1;
   localparam logic [7:0] CMD_DISP_OFF    = 8'd2;
   localparam logic [7:0] CMD_DISP_ON     = 8'd3;
   localparam logic [7:0] CMD_CURS_OFF    = 8'd4;
   localparam logic [7:0] CMD_CURS_ON_A   = 8'd5;
   localparam logic [7:0] CMD_CURS_ON_B   = 8'd6;
   localparam logic [7:0] CMD_CURS_ON_C   = 8'd7;
   localparam logic [7:0] CMD_BACKSPACE   = 8'd8;
   localparam logic [7:0] CMD_LINE_FEED   = 8'd10;
   localparam logic [7:0] CMD_DELETE      = 8'd11;
   localparam logic [7:0] CMD_FORM_FEED   = 8'd12;
   localparam logic [7:0] CMD_CR          = 8'd13;
   localparam logic [7:0] CMD_BACKLIGHT   = 8'd14;
   localparam logic [7:0] CMD_CONTRAST    = 8'd15;
   localparam logic [7:0] CMD_SET_POS     = 8'd17;
   localparam logic [7:0] CMD_SCROLL_ON   = 8'd19;
   localparam logic [7:0] CMD_SCROLL_OFF  = 8'd20;
   localparam logic [7:0] CMD_WRAP_ON     = 8'd23;
   localparam logic [7:0] CMD_WRAP_OFF    = 8'd24;
   localparam logic [7:0] CMD_REBOOT      = 8'd26;
   localparam logic [7:0] CMD_ESCAPE      = 8'd27;
   localparam logic [7:0] CHAR_FIRST      = 8'd32;
   localparam logic [7:0] CHAR_LAST       = 8'd255;

   // Escape direction bytes
   localparam logic [7:0] DIR_UP    = 8'd65;
   localparam logic [7:0] DIR_DOWN  = 8'd66;
   localparam logic [7:0] DIR_RIGHT = 8'd67;
   localparam logic [7:0] DIR_LEFT  = 8'd68;

   localparam logic [7:0] LEVEL_MAX  = 8'd100;
   localparam logic [6:0] LEVEL_FULL = 7'd100;
   localparam logic [7:0] SPACE_CHAR = 8'h20;

   // Item function codes
   localparam logic FUNC_BYTE = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   // Result queue depth
   localparam int Q_DEPTH = 3;
   localparam int Q_PTR_W = 2;

   typedef struct packed {
      logic       func;
      logic [7:0] rx_byte;
      logic [1:0] read_row;
      logic [4:0] read_col;
   } req_type;

   typedef struct packed {
      logic       changed;
      logic [1:0] cur_row;
      logic [4:0] cur_col;
      logic       display_on;
      logic       cursor_on;
      logic       wrap_on;
      logic       scroll_on;
      logic [6:0] backlight;
      logic [6:0] contrast_level;
      logic [7:0] cell_char;
   } rsp_type;

endpackage

>>> rtl/core/char_lcd_command_interpreter_core.sv
// Serial character LCD command interpreter. Each item is either one received
// command byte or a read of one display cell, and gives exactly one result
// with the changed flag and the full status. One item is accepted per clock
// while req_ready is high; a result passes through the stage register (state
// update and cell store read) and then the result queue before it reaches rsp.
// Up to three results may wait for rsp_ready, and req_ready falls once the
// queue and the stage ahead of it hold three results between them. The
// character store is a one-write, one-read memory with a valid bit per cell,
// so reset, form feed and reboot blank the whole display by clearing every valid bit.
// Configuration writes are taken at any time and must only be issued while
// the block is idle.
module char_lcd_command_interpreter_core #(
   parameter int MAX_ROWS = clci_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS = clci_pkg::MAX_COLS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  clci_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output clci_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [4:0]        csr_wdata
);

   import clci_pkg::*;

   localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int RE_W   = $clog2(MAX_ROWS + 1);
   localparam int COL_W  = $clog2(MAX_COLS + 1);
   localparam int DEPTH  = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int ROWS_RST = (ROWS_RESET > MAX_ROWS) ? MAX_ROWS : ROWS_RESET;
   localparam int COLS_RST = (COLS_RESET > MAX_COLS) ? MAX_COLS : COLS_RESET;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_POS_COL,
      PH_POS_ROW,
      PH_LIGHT,
      PH_CONTRAST,
      PH_ESC1,
      PH_ESC2
   } phase_type;

   typedef enum logic [1:0] {
      CELL_ZERO,
      CELL_SPACE,
      CELL_MEM
   } cell_src_type;

   function automatic logic [ADDR_W-1:0] cell_index(input logic [7:0] row,
                                                   input logic [7:0] col);
      return ADDR_W'(int'(row) * MAX_COLS + int'(col));
   endfunction

   // Configuration (held as effective, clamped values)
   logic [RE_W-1:0]  rows_eff_ff, rows_eff_in;
   logic [COL_W-1:0] cols_eff_ff, cols_eff_in;

   // Display state
   logic [ROW_W-1:0] cursor_row_ff, cursor_row_in;
   logic [COL_W-1:0] cursor_col_ff, cursor_col_in;
   logic             display_ff, display_in;
   logic             cursor_ff, cursor_in;
   logic             wrap_ff, wrap_in;
   logic             scroll_ff, scroll_in;
   logic [6:0]       bright_ff, bright_in;
   logic [6:0]       contrast_ff, contrast_in;
   phase_type        phase_ff, phase_in;
   logic [7:0]       pending_ff, pending_in;
   logic [DEPTH-1:0] cell_vld_ff, cell_vld_in;

   // Cell store
   logic [7:0]       cell_mem [DEPTH];
   logic [7:0]       rd_data_ff;

   // Stage between accept and the result queue
   logic             p_valid_ff;
   rsp_type          p_rsp_ff, p_rsp_in;
   cell_src_type     p_sel_ff, p_sel_in;

   // Result queue
   rsp_type          q_mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] q_wp_ff, q_wp_in;
   logic [Q_PTR_W-1:0] q_rp_ff, q_rp_in;
   logic [Q_PTR_W-1:0] q_cnt_ff, q_cnt_in;

   // Command decode
   logic             accept;
   logic             do_idle;
   logic             changed;
   logic             clr_all;
   logic             wr_req;
   logic             wr_en;
   logic [COL_W-1:0] wr_col;
   logic [7:0]       wr_data;
   logic [ADDR_W-1:0] wr_addr;
   logic             rd_en;
   logic             rd_hit;
   logic [ADDR_W-1:0] rd_addr;
   logic [ROW_W:0]   row_inc;
   logic [COL_W:0]   col_inc;
   logic             push;
   logic             pop;
   logic [Q_PTR_W:0] in_flight;
   rsp_type          push_rsp;

   // Admit an item only when the queue has room for everything in flight
   assign in_flight = {1'b0, q_cnt_ff} + {{Q_PTR_W{1'b0}}, p_valid_ff};
   assign req_ready = in_flight < (Q_PTR_W + 1)'(Q_DEPTH);
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // Clamp configuration writes to the supported geometry
   always_comb begin
      rows_eff_in = rows_eff_ff;
      cols_eff_in = cols_eff_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_ROWS: begin
               if (csr_wdata[2:0] == 3'd0) begin
                  rows_eff_in = RE_W'(1);
               end else if (csr_wdata[2:0] > MAX_ROWS) begin
                  rows_eff_in = RE_W'(MAX_ROWS);
               end else begin
                  rows_eff_in = RE_W'(csr_wdata[2:0]);
               end
            end
            CSR_COLS: begin
               if (csr_wdata == 5'd0) begin
                  cols_eff_in = COL_W'(1);
               end else if (csr_wdata > MAX_COLS) begin
                  cols_eff_in = COL_W'(MAX_COLS);
               end else begin
                  cols_eff_in = COL_W'(csr_wdata);
               end
            end
            default: ;
         endcase
      end
   end

   assign row_inc = {1'b0, cursor_row_ff} + (ROW_W + 1)'(1);
   assign col_inc = {1'b0, cursor_col_ff} + (COL_W + 1)'(1);

   // Interpret one command byte
   always_comb begin
      cursor_row_in = cursor_row_ff;
      cursor_col_in = cursor_col_ff;
      display_in    = display_ff;
      cursor_in     = cursor_ff;
      wrap_in       = wrap_ff;
      scroll_in     = scroll_ff;
      bright_in     = bright_ff;
      contrast_in   = contrast_ff;
      phase_in      = phase_ff;
      pending_in    = pending_ff;
      do_idle       = 1'b0;
      changed       = 1'b0;
      clr_all       = 1'b0;
      wr_req        = 1'b0;
      wr_col        = cursor_col_ff;
      wr_data       = SPACE_CHAR;

      if (accept && req_data.func == FUNC_BYTE) begin
         phase_in = PH_IDLE;
         unique case (phase_ff)
            PH_POS_COL: begin
               pending_in = req_data.rx_byte;
               phase_in   = PH_POS_ROW;
            end
            PH_POS_ROW: begin
               if (pending_ff < cols_eff_ff && req_data.rx_byte < rows_eff_ff) begin
                  cursor_col_in = COL_W'(pending_ff);
                  cursor_row_in = ROW_W'(req_data.rx_byte);
                  changed       = 1'b1;
               end
            end
            PH_LIGHT: begin
               if (req_data.rx_byte <= LEVEL_MAX) begin
                  bright_in = req_data.rx_byte[6:0];
                  changed   = 1'b1;
               end
            end
            PH_CONTRAST: begin
               if (req_data.rx_byte <= LEVEL_MAX) begin
                  contrast_in = req_data.rx_byte[6:0];
                  changed     = 1'b1;
               end
            end
            PH_ESC1: begin
               // A broken escape drops and reparses its second byte
               if (req_data.rx_byte == CMD_ESCAPE) begin
                  phase_in = PH_ESC2;
               end else begin
                  do_idle = 1'b1;
               end
            end
            PH_ESC2: begin
               unique case (req_data.rx_byte)
                  DIR_UP: begin
                     if (cursor_row_ff != '0) begin
                        cursor_row_in = cursor_row_ff - ROW_W'(1);
                        changed       = 1'b1;
                     end
                  end
                  DIR_DOWN: begin
                     if (row_inc < rows_eff_ff) begin
                        cursor_row_in = row_inc[ROW_W-1:0];
                        changed       = 1'b1;
                     end
                  end
                  DIR_RIGHT: begin
                     if (col_inc < cols_eff_ff) begin
                        cursor_col_in = col_inc[COL_W-1:0];
                        changed       = 1'b1;
                     end
                  end
                  DIR_LEFT: begin
                     if (cursor_col_ff != '0) begin
                        cursor_col_in = cursor_col_ff - COL_W'(1);
                        changed       = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
            default: do_idle = 1'b1;
         endcase
      end

      if (do_idle) begin
         unique case (req_data.rx_byte) inside
            CMD_HOME: begin
               cursor_row_in = '0;
               cursor_col_in = '0;
               changed       = 1'b1;
            end
            CMD_DISP_OFF: begin
               display_in = 1'b0;
               changed    = 1'b1;
            end
            CMD_DISP_ON: begin
               display_in = 1'b1;
               changed    = 1'b1;
            end
            CMD_CURS_OFF: begin
               cursor_in = 1'b0;
               changed   = 1'b1;
            end
            CMD_CURS_ON_A, CMD_CURS_ON_B, CMD_CURS_ON_C: begin
               cursor_in = 1'b1;
               changed   = 1'b1;
            end
            CMD_BACKSPACE: begin
               if (cursor_col_ff != '0) begin
                  cursor_col_in = cursor_col_ff - COL_W'(1);
                  wr_col        = cursor_col_ff - COL_W'(1);
                  wr_req        = 1'b1;
                  changed       = 1'b1;
               end
            end
            CMD_LINE_FEED: begin
               if (row_inc < rows_eff_ff) begin
                  cursor_row_in = row_inc[ROW_W-1:0];
                  changed       = 1'b1;
               end
            end
            CMD_DELETE: begin
               wr_req  = 1'b1;
               changed = 1'b1;
            end
            CMD_FORM_FEED: begin
               clr_all       = 1'b1;
               cursor_row_in = '0;
               cursor_col_in = '0;
               changed       = 1'b1;
            end
            CMD_CR: begin
               cursor_col_in = '0;
               changed       = 1'b1;
            end
            CMD_BACKLIGHT: phase_in = PH_LIGHT;
            CMD_CONTRAST:  phase_in = PH_CONTRAST;
            CMD_SET_POS:   phase_in = PH_POS_COL;
            CMD_SCROLL_ON: begin
               scroll_in = 1'b1;
               changed   = 1'b1;
            end
            CMD_SCROLL_OFF: begin
               scroll_in = 1'b0;
               changed   = 1'b1;
            end
            CMD_WRAP_ON: begin
               wrap_in = 1'b1;
               changed = 1'b1;
            end
            CMD_WRAP_OFF: begin
               wrap_in = 1'b0;
               changed = 1'b1;
            end
            CMD_REBOOT: begin
               // Keep backlight and contrast levels
               clr_all       = 1'b1;
               cursor_row_in = '0;
               cursor_col_in = '0;
               display_in    = 1'b0;
               cursor_in     = 1'b1;
               wrap_in       = 1'b0;
               scroll_in     = 1'b0;
               changed       = 1'b1;
            end
            CMD_ESCAPE: phase_in = PH_ESC1;
            [CHAR_FIRST:CHAR_LAST]: begin
               // Drop a printable byte once the column reaches the end
               if (cursor_col_ff < cols_eff_ff) begin
                  wr_req        = 1'b1;
                  wr_data       = req_data.rx_byte;
                  cursor_col_in = col_inc[COL_W-1:0];
                  changed       = 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   // Write only cells inside the area in use
   assign wr_en   = wr_req && cursor_row_ff < rows_eff_ff && wr_col < cols_eff_ff;
   assign wr_addr = cell_index(8'(cursor_row_ff), 8'(wr_col));

   // Read port
   assign rd_en   = accept && req_data.func == FUNC_READ;
   assign rd_hit  = req_data.read_row < rows_eff_ff && req_data.read_col < cols_eff_ff;
   assign rd_addr = cell_index(8'(req_data.read_row), 8'(req_data.read_col));

   // Track which cells hold a written character
   always_comb begin
      cell_vld_in = cell_vld_ff;
      if (clr_all) begin
         cell_vld_in = '0;
      end else if (wr_en) begin
         cell_vld_in[wr_addr] = 1'b1;
      end
   end

   // Choose the cell source and build the status
   always_comb begin
      p_sel_in = CELL_ZERO;
      if (rd_en && rd_hit) begin
         p_sel_in = cell_vld_ff[rd_addr] ? CELL_MEM : CELL_SPACE;
      end
      p_rsp_in.changed        = changed;
      p_rsp_in.cur_row        = 2'(cursor_row_in);
      p_rsp_in.cur_col        = 5'(cursor_col_in);
      p_rsp_in.display_on     = display_in;
      p_rsp_in.cursor_on      = cursor_in;
      p_rsp_in.wrap_on        = wrap_in;
      p_rsp_in.scroll_on      = scroll_in;
      p_rsp_in.backlight      = bright_in;
      p_rsp_in.contrast_level = contrast_in;
      p_rsp_in.cell_char      = 8'd0;
   end

   // Complete the result with the cell read
   always_comb begin
      push_rsp = p_rsp_ff;
      case (p_sel_ff)
         CELL_MEM:   push_rsp.cell_char = rd_data_ff;
         CELL_SPACE: push_rsp.cell_char = SPACE_CHAR;
         default:    push_rsp.cell_char = 8'd0;
      endcase
   end

   // Advance the result queue pointers
   assign push      = p_valid_ff;
   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = q_cnt_ff != '0;
   assign rsp_data  = q_mem_ff[q_rp_ff];

   always_comb begin
      q_wp_in  = q_wp_ff;
      q_rp_in  = q_rp_ff;
      q_cnt_in = q_cnt_ff;
      if (push) begin
         q_wp_in = (q_wp_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : q_wp_ff + Q_PTR_W'(1);
      end
      if (pop) begin
         q_rp_in = (q_rp_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : q_rp_ff + Q_PTR_W'(1);
      end
      if (push && !pop) begin
         q_cnt_in = q_cnt_ff + Q_PTR_W'(1);
      end else if (pop && !push) begin
         q_cnt_in = q_cnt_ff - Q_PTR_W'(1);
      end
   end

   // Hold control and display state
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_eff_ff   <= RE_W'(ROWS_RST);
         cols_eff_ff   <= COL_W'(COLS_RST);
         cursor_row_ff <= '0;
         cursor_col_ff <= '0;
         display_ff    <= 1'b0;
         cursor_ff     <= 1'b1;
         wrap_ff       <= 1'b0;
         scroll_ff     <= 1'b0;
         bright_ff     <= LEVEL_FULL;
         contrast_ff   <= '0;
         phase_ff      <= PH_IDLE;
         pending_ff    <= '0;
         cell_vld_ff   <= '0;
         p_valid_ff    <= 1'b0;
         q_wp_ff       <= '0;
         q_rp_ff       <= '0;
         q_cnt_ff      <= '0;
      end else begin
         rows_eff_ff   <= rows_eff_in;
         cols_eff_ff   <= cols_eff_in;
         cursor_row_ff <= cursor_row_in;
         cursor_col_ff <= cursor_col_in;
         display_ff    <= display_in;
         cursor_ff     <= cursor_in;
         wrap_ff       <= wrap_in;
         scroll_ff     <= scroll_in;
         bright_ff     <= bright_in;
         contrast_ff   <= contrast_in;
         phase_ff      <= phase_in;
         pending_ff    <= pending_in;
         cell_vld_ff   <= cell_vld_in;
         p_valid_ff    <= accept;
         q_wp_ff       <= q_wp_in;
         q_rp_ff       <= q_rp_in;
         q_cnt_ff      <= q_cnt_in;
      end
   end

   // Load the stage payload on accept
   always_ff @(posedge clock) begin
      if (accept) begin
         p_rsp_ff <= p_rsp_in;
         p_sel_ff <= p_sel_in;
      end
   end

   // Cell store
   always_ff @(posedge clock) begin
      if (wr_en) begin
         cell_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= cell_mem[rd_addr];
      end
   end

   // Result queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[q_wp_ff] <= push_rsp;
      end
   end

   // The queue never takes a result it has no room for
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |-> (q_cnt_ff != Q_PTR_W'(Q_DEPTH)))
      else $error("result queue overflow");

   // A read item leaves the cursor and the parser untouched
   a_read_stable: assert property (@(posedge clock) disable iff (reset)
      rd_en |=> ($stable(cursor_row_ff) && $stable(cursor_col_ff) && $stable(phase_ff)
                 && $stable(cell_vld_ff)))
      else $error("read item changed state");

   // Blanking leaves no cell marked as written
   a_clear: assert property (@(posedge clock) disable iff (reset)
      clr_all |=> (cell_vld_ff == '0))
      else $error("store not blanked");

   // The cursor column never passes the column limit
   a_col_limit: assert property (@(posedge clock) disable iff (reset)
      accept |=> (cursor_col_ff <= COL_W'(MAX_COLS)))
      else $error("cursor column out of range");

endmodule
